// File: rtl/core/bpc_pkg.sv
// Package for the button press count and hold timer.
// Field widths, command codes, controller/datapath handshake structs.
// No dependencies.
package bpc_pkg;

  // Default number of buttons tracked
  localparam int BUTTON_COUNT_DEF = 11;

  // Field widths fixed by the item format
  localparam int CMD_W    = 3;
  localparam int BUTTON_W = 4;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 32;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PRESS      = 3'd0,
    CMD_RELEASE    = 3'd1,
    CMD_READ_COUNT = 3'd2,
    CMD_READ_TIME  = 3'd3,
    CMD_FLUSH      = 3'd4
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic execute;   // update the button state and load the result
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free; // result register empty or being emptied this cycle
  } dp_status_t;

endpackage

// File: rtl/core/bpc_if.sv
// Channel interfaces for the button press count and hold timer.
// Request, result and configuration channels; depends on bpc_pkg.
interface bpc_req_if import bpc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [CMD_W-1:0]    command;
  logic        [BUTTON_W-1:0] button;
  logic signed [TIME_W-1:0]   now;
  modport source (output valid, command, button, now, input ready);
  modport sink   (input valid, command, button, now, output ready);
endinterface

interface bpc_res_if import bpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [COUNT_W-1:0] down_count;
  logic signed [TIME_W-1:0]  down_time;
  logic                      is_pressed;
  modport source (output valid, down_count, down_time, is_pressed, input ready);
  modport sink   (input valid, down_count, down_time, is_pressed, output ready);
endinterface

interface bpc_cfg_if ();
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/button_press_count_and_hold_timer.sv
// Top level of the button press count and hold timer.
// Depends on bpc_pkg, bpc_if, bpc_ctrl and bpc_datapath.
//
// Usage:
//   req  carries one request: command, button index and the current
//        signed 16.16 time. Press, release, read down count, read down
//        time and flush are served; flush is ignored while enabled is 0.
//   res  returns exactly one result per request: down count, down time
//        and the addressed button's pressed state after the request.
//   cfg  writes the enabled flag; it is always ready.
// Timing:
//   A request is accepted when the block is idle and latched (capture); it
//   executes once the result register can take the answer, and its result
//   is registered at execution. One request is in flight at a time, so the
//   next is accepted only once the last has executed (capture, then execute).
// Stalls: the result register frees on the cycle it is taken, so a new
//   request may be accepted while a result waits; execution holds while
//   the result register stays full.
// Reset (rst, synchronous): every button up, all times and counts zero,
//   enabled cleared, no result pending.
module button_press_count_and_hold_timer import bpc_pkg::*; #(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bpc_req_if.sink   req,
  bpc_res_if.source res,
  bpc_cfg_if.sink   cfg
);

  dp_ctrl_t   ctrl;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  bpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  bpc_datapath #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .status         (status),
    .req_command    (req.command),
    .req_button     (req.button),
    .req_now        (req.now),
    .cfg_valid      (cfg.valid),
    .cfg_data       (cfg.data),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_down_count (res.down_count),
    .res_down_time  (res.down_time),
    .res_is_pressed (res.is_pressed)
  );

endmodule

// File: rtl/core/bpc_ctrl.sv
// Controller for the button press count and hold timer.
// Two-state one-hot machine sequencing capture and execute; uses bpc_pkg.
module bpc_ctrl import bpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t status,
  output dp_ctrl_t   ctrl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Accept a request only when no item is in flight
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    ctrl.capture = 1'b0;
    ctrl.execute = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          ctrl.capture = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Hold until the result register can take the answer
        if (status.slot_free) begin
          ctrl.execute = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/bpc_datapath.sv
// Datapath for the button press count and hold timer.
// Per-button register arrays, request latch, result register; uses bpc_pkg.
module bpc_datapath import bpc_pkg::*; #(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dp_ctrl_t                   ctrl,
  output dp_status_t                 status,
  input  logic        [CMD_W-1:0]    req_command,
  input  logic        [BUTTON_W-1:0] req_button,
  input  logic signed [TIME_W-1:0]   req_now,
  input  logic                       cfg_valid,
  input  logic                       cfg_data,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic        [COUNT_W-1:0]  res_down_count,
  output logic signed [TIME_W-1:0]   res_down_time,
  output logic                       res_is_pressed
);

  localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  // Per-button state
  logic                pressed   [BUTTON_COUNT];
  logic [TIME_W-1:0]   mark      [BUTTON_COUNT];
  logic [TIME_W-1:0]   held      [BUTTON_COUNT];
  logic [COUNT_W-1:0]  cnt       [BUTTON_COUNT];

  logic                enabled;

  // Latched request
  logic [CMD_W-1:0]    cmd_q;
  logic [BUTTON_W-1:0] button_q;
  logic [TIME_W-1:0]   now_q;

  logic                in_range;
  logic [IDX_W-1:0]    idx;
  logic                flag_cur;
  logic [TIME_W-1:0]   mark_cur;
  logic [TIME_W-1:0]   held_cur;
  logic [COUNT_W-1:0]  cnt_cur;
  logic                flag_new;
  logic [TIME_W-1:0]   mark_new;
  logic [TIME_W-1:0]   held_new;
  logic [COUNT_W-1:0]  cnt_new;
  logic [COUNT_W-1:0]  count_out;
  logic [TIME_W-1:0]   time_out;
  logic [TIME_W-1:0]   elapsed;
  logic                is_flush;
  logic                flush_en;
  logic                entry_we;

  assign status.slot_free = !res_valid || res_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg_valid) begin
      enabled <= cfg_data;
    end
  end

  // Latch the request on capture
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q    <= req_command;
      button_q <= req_button;
      now_q    <= req_now;
    end
  end

  // Select the addressed entry
  assign in_range = {2'b00, button_q} < 6'(BUTTON_COUNT);
  assign idx      = in_range ? IDX_W'(button_q) : '0;
  assign flag_cur = pressed[idx];
  assign mark_cur = mark[idx];
  assign held_cur = held[idx];
  assign cnt_cur  = cnt[idx];
  assign elapsed  = now_q - mark_cur;
  assign is_flush = (cmd_q == CMD_FLUSH);

  // Work out the new entry and the answer
  always_comb begin
    flag_new  = flag_cur;
    mark_new  = mark_cur;
    held_new  = held_cur;
    cnt_new   = cnt_cur;
    count_out = '0;
    time_out  = '0;
    case (cmd_q)
      CMD_PRESS: begin
        if (!flag_cur) begin
          flag_new = 1'b1;
          mark_new = now_q;
        end
        cnt_new = cnt_cur + COUNT_W'(1);
      end
      CMD_RELEASE: begin
        if (flag_cur) begin
          flag_new = 1'b0;
          held_new = held_cur + elapsed;
        end
      end
      CMD_READ_COUNT: begin
        count_out = cnt_cur;
        cnt_new   = '0;
      end
      CMD_READ_TIME: begin
        if (!flag_cur) begin
          time_out = held_cur;
          held_new = '0;
        end else begin
          time_out = elapsed;
          mark_new = now_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign flush_en = ctrl.execute && is_flush && enabled;
  assign entry_we = ctrl.execute && !is_flush && in_range;

  // Update per-button state: flush sweeps every entry at once
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        pressed[i] <= 1'b0;
        mark[i]    <= '0;
        held[i]    <= '0;
        cnt[i]     <= '0;
      end
    end else if (flush_en) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        pressed[i] <= 1'b0;
        mark[i]    <= now_q;
        held[i]    <= '0;
        cnt[i]     <= '0;
      end
    end else if (entry_we) begin
      pressed[idx] <= flag_new;
      mark[idx]    <= mark_new;
      held[idx]    <= held_new;
      cnt[idx]     <= cnt_new;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.execute) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      res_down_count <= (in_range && !is_flush) ? count_out : '0;
      res_down_time  <= (in_range && !is_flush) ? time_out : '0;
      res_is_pressed <= in_range && !(is_flush && enabled) && flag_new;
    end
  end

endmodule

// File: rtl/core/bpc_checker.sv
// Port-level checks for the button press count and hold timer.
// Bound to the top level; depends on bpc_pkg.
module bpc_checker import bpc_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic        [COUNT_W-1:0] res_down_count,
  input logic signed [TIME_W-1:0]  res_down_time,
  input logic                      res_is_pressed
);

  // Drop any pending result on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Hold a stalled result unchanged
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_down_count)
      && $stable(res_down_time) && $stable(res_is_pressed))
    else $error("stalled result changed");

  // A fresh result follows an accepted request
  a_res_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_valid && req_ready, 2))
    else $error("result without a request");

  // Never return a count and a time in the same result
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_down_count == '0) || (res_down_time == '0))
    else $error("count and time both set");

endmodule

bind button_press_count_and_hold_timer bpc_checker u_bpc_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_down_count (res.down_count),
  .res_down_time  (res.down_time),
  .res_is_pressed (res.is_pressed)
);

// File: sim/tb.sv
// Testbench for the button press count and hold timer: directed and random requests.
// Depends on bpc_pkg, the channel interfaces in bpc_if and the top level
// button_press_count_and_hold_timer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpc_pkg::*;

  localparam int NB          = BUTTON_COUNT_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 27;
  localparam int PHASE_ITEMS = 140;

  typedef struct packed {
    logic [COUNT_W-1:0] down_count;
    logic [TIME_W-1:0]  down_time;
    logic               is_pressed;
  } button_result_t;

  // Tracks every button as the block should and holds the results still owed
  class button_tracker;
    bit                 enabled;
    bit                 pressed  [NB];
    bit [TIME_W-1:0]    mark     [NB];
    bit [TIME_W-1:0]    held     [NB];
    bit [COUNT_W-1:0]   presses  [NB];
    button_result_t     expected_results [$];
    int                 mismatches;

    function new();
      enabled    = 1'b0;
      mismatches = 0;
      for (int i = 0; i < NB; i++) begin
        pressed[i] = 1'b0;
        mark[i]    = '0;
        held[i]    = '0;
        presses[i] = '0;
      end
    endfunction

    // Apply one accepted request and queue the result it must give
    function void note_request(bit [CMD_W-1:0] cmd, bit [BUTTON_W-1:0] btn,
                               bit [TIME_W-1:0] now);
      button_result_t r;
      bit             in_range;
      r        = '0;
      in_range = btn < NB;
      if (cmd == CMD_FLUSH) begin
        if (enabled) begin
          for (int i = 0; i < NB; i++) begin
            pressed[i] = 1'b0;
            mark[i]    = now;
            held[i]    = '0;
            presses[i] = '0;
          end
        end
      end else if (in_range) begin
        case (cmd)
          CMD_PRESS: begin
            if (!pressed[btn]) begin
              pressed[btn] = 1'b1;
              mark[btn]    = now;
            end
            presses[btn] = presses[btn] + 1;
          end
          CMD_RELEASE: begin
            if (pressed[btn]) begin
              pressed[btn] = 1'b0;
              held[btn]    = held[btn] + (now - mark[btn]);
            end
          end
          CMD_READ_COUNT: begin
            r.down_count = presses[btn];
            presses[btn] = '0;
          end
          CMD_READ_TIME: begin
            // a down button reports the time since its mark and re-marks
            if (!pressed[btn]) begin
              r.down_time = held[btn];
              held[btn]   = '0;
            end else begin
              r.down_time = now - mark[btn];
              mark[btn]   = now;
            end
          end
          default: ;
        endcase
      end
      if (in_range) r.is_pressed = pressed[btn];
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
    endtask

    // Compare one returned result with the oldest one owed
    task check_result(logic [COUNT_W-1:0] cnt, logic [TIME_W-1:0] tm, logic pr);
      button_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unrequested result", cnt, '0);
      end else begin
        want = expected_results.pop_front();
        if (cnt !== want.down_count) report_mismatch("down_count", cnt, want.down_count);
        if (tm !== want.down_time) report_mismatch("down_time", tm, want.down_time);
        if (pr !== want.is_pressed)
          report_mismatch("is_pressed", 32'(pr), 32'(want.is_pressed));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   steady;
  int   cycles;

  button_tracker tracker = new();

  bpc_req_if req_ch ();
  bpc_res_if res_ch ();
  bpc_cfg_if cfg_ch ();

  button_press_count_and_hold_timer #(.BUTTON_COUNT(NB)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // Clock generator
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Take results with random back-pressure and check them
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        tracker.check_result(res_ch.down_count, res_ch.down_time, res_ch.is_pressed);
      res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offer one request, idling first at random, and hold it until taken
  task automatic send_request(bit [CMD_W-1:0] cmd, bit [BUTTON_W-1:0] btn,
                              bit [TIME_W-1:0] now);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.button  <= btn;
    req_ch.now     <= now;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_request(cmd, btn, now);
  endtask

  // Drop the request line and wait for every owed result
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_enabled(bit value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.enabled = value;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    bit [TIME_W-1:0]   clock_now;
    bit [CMD_W-1:0]    cmd;
    bit [BUTTON_W-1:0] btn;
    bit                phase_enabled [6];
    int                pick;

    phase_enabled = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    rst            = 1'b1;
    steady         = 1'b0;
    cycles         = 0;
    req_ch.valid   = 1'b0;
    req_ch.command = '0;
    req_ch.button  = '0;
    req_ch.now     = '0;
    res_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: fresh state, wrap-around times, repeats, bad indexes, disabled flush
    write_enabled(1'b0);
    send_request(CMD_READ_COUNT, 4'd0, 32'h0000_0000);
    send_request(CMD_READ_TIME, 4'd10, 32'h0001_0000);
    send_request(CMD_PRESS, 4'd0, 32'h8000_0000);
    send_request(CMD_PRESS, 4'd0, 32'h0000_0000);
    send_request(CMD_READ_TIME, 4'd0, 32'h7FFF_FFFF);
    send_request(CMD_RELEASE, 4'd0, 32'hFFFF_FFFF);
    send_request(CMD_RELEASE, 4'd0, 32'h0000_1234);
    send_request(CMD_READ_TIME, 4'd0, 32'h0000_5678);
    send_request(CMD_READ_COUNT, 4'd0, 32'h0000_0000);
    send_request(CMD_PRESS, 4'd10, 32'h0001_2345);
    send_request(CMD_PRESS, 4'd11, 32'h0002_0000);
    send_request(CMD_RELEASE, 4'd15, 32'hFFFF_0000);
    send_request(CMD_READ_COUNT, 4'd15, 32'h0000_0001);
    send_request(3'd5, 4'd10, 32'h0000_0002);
    send_request(3'd7, 4'd15, 32'h0000_0003);
    send_request(3'd6, 4'd3, 32'h0000_0004);
    send_request(CMD_FLUSH, 4'd10, 32'h0003_0000);
    send_request(CMD_READ_TIME, 4'd10, 32'h0004_0000);
    drain();

    // Directed: flush while enabled, with an out-of-range index
    write_enabled(1'b1);
    send_request(CMD_PRESS, 4'd3, 32'h0005_0000);
    send_request(CMD_FLUSH, 4'd15, 32'h7FFF_0000);
    send_request(CMD_READ_TIME, 4'd3, 32'h7FFF_8000);
    send_request(CMD_READ_COUNT, 4'd10, 32'h7FFF_9000);
    send_request(CMD_PRESS, 4'd5, 32'h7FFF_A000);
    send_request(CMD_RELEASE, 4'd5, 32'h8000_1000);
    drain();

    // Random phases, one enabled setting each, one with no idling at all
    clock_now = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      write_enabled(phase_enabled[ph]);
      steady = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 10) clock_now = $urandom;
        else clock_now = clock_now + $urandom_range(1, 4000);
        if ($urandom_range(0, 99) < 90) btn = BUTTON_W'($urandom_range(0, NB - 1));
        else btn = BUTTON_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 30) cmd = CMD_PRESS;
        else if (pick < 60) cmd = CMD_RELEASE;
        else if (pick < 72) cmd = CMD_READ_COUNT;
        else if (pick < 87) cmd = CMD_READ_TIME;
        else if (pick < 91) cmd = CMD_FLUSH;
        else cmd = CMD_W'($urandom_range(5, 7));
        send_request(cmd, btn, clock_now);
      end
      drain();
      steady = 1'b0;
    end

    // Let any stray result show up before the verdict
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/bpc_pkg.sv
rtl/core/bpc_if.sv
rtl/core/bpc_ctrl.sv
rtl/core/bpc_datapath.sv
rtl/core/button_press_count_and_hold_timer.sv
rtl/core/bpc_checker.sv
sim/tb.sv
